>>> rtl/lszp_pkg.sv
// Shared types and constants for the laser scan z-buffer projector.
// Holds the sequencer states, action and register codes, and the CORDIC angle table.
// No dependencies.
`default_nettype none
package lszp_pkg;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_XMUL,
		ST_XFIN,
		ST_CINIT,
		ST_CORD,
		ST_POST,
		ST_BIN,
		ST_LOOK,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_PROJECT = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	localparam logic [2:0] REG_NUM_BINS    = 3'd0;
	localparam logic [2:0] REG_BINS_PER_RAD = 3'd1;
	localparam logic [2:0] REG_ROT_COS     = 3'd2;
	localparam logic [2:0] REG_ROT_SIN     = 3'd3;
	localparam logic [2:0] REG_TRANS_X     = 3'd4;
	localparam logic [2:0] REG_TRANS_Y     = 3'd5;
	localparam logic [2:0] REG_EMPTY_LABEL = 3'd6;

	localparam logic [31:0] CLEAR_RANGE  = 32'd65536000;
	localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

	// Arctangent of 2^-i, 2^32 units per full turn
	function automatic logic [31:0] atan_fn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/laser_scan_zbuffer_projector_core.sv
// Projection runs transform, CORDIC setup, CORDIC steps, post-processing, bin/memory and output
// in order; a read goes straight to the memory lookup, clear sweeps the bin memory, others just emit.
// One shared 34x34 multiplier and one CORDIC add/shift stage are reused under a sequencer.
// One item at a time; a new item is taken once the result is loaded into the output register.
// Reset clears control and configuration registers, then sweeps the bin memory one entry per cycle
// to range 1000.0 and label 0 before the first item is accepted.
`default_nettype none
module laser_scan_zbuffer_projector_core import lszp_pkg::*; #(
	parameter int MAX_BINS     = 1024,
	parameter int CORDIC_STEPS = 20
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [87:0] s_tdata,   // point_x[31:0], point_y[63:32], point_label[71:64], read_bin[81:72]
	input  wire  [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // in_view[0], updated[1], bin_index[11:2], bin_range[43:12], bin_label[51:44]
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_addr,
	input  wire  [31:0] cfg_data
);

	localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = 40;
	localparam logic [BW-1:0] LAST_BIN = BW'(MAX_BINS - 1);
	localparam logic [4:0] LAST_IT = 5'(CORDIC_STEPS - 1);
	localparam logic [16:0] MAXB = 17'(MAX_BINS);

	state_t state_q, state_d;

	logic [10:0] num_bins_q;
	logic [31:0] bpr_q;
	logic signed [17:0] cos_q, sin_q;
	logic signed [31:0] tx_q, ty_q;
	logic [7:0] empty_q;

	logic [1:0] act_q;
	logic signed [31:0] px_q, py_q;
	logic [7:0] lbl_q;
	logic [9:0] rb_q;
	logic [2:0] cnt_q;
	logic [4:0] it_q;
	logic [BW-1:0] sweep_q;
	logic [7:0] sweep_lbl_q;
	logic sweep_emit_q;

	logic signed [67:0] prod_q;
	logic signed [51:0] xacc_q, yacc_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [33:0] ang_q;
	logic [31:0] t_q, rng_q;
	logic [34:0] bq_q;
	logic [BW-1:0] bin_q;
	logic addr_ok_q;
	logic [31:0] rdr_q;
	logic [7:0] rdl_q;

	logic r_view_q, r_upd_q;
	logic [9:0] r_idx_q;
	logic [31:0] r_rng_q;
	logic [7:0] r_lbl_q;

	logic [31:0] range_mem [MAX_BINS];
	logic [7:0] label_mem [MAX_BINS];

	// Shared multiplier operands
	logic signed [33:0] opa, opb;
	logic signed [67:0] prod_c;
	logic [32:0] am;

	assign am = ang_q[33] ? 33'(-ang_q) : 33'(ang_q);

	always_comb begin
		opa = '0;
		opb = '0;
		if (state_q == ST_XMUL) begin
			case (cnt_q)
				3'd0: begin opa = 34'(cos_q); opb = 34'(px_q); end
				3'd1: begin opa = 34'(sin_q); opb = 34'(py_q); end
				3'd2: begin opa = 34'(sin_q); opb = 34'(px_q); end
				3'd3: begin opa = 34'(cos_q); opb = 34'(py_q); end
				default: begin opa = '0; opb = '0; end
			endcase
		end else if (state_q == ST_POST) begin
			case (cnt_q)
				3'd0: begin opa = {18'd0, cx_q[15:0]}; opb = {2'd0, INV_GAIN_Q32}; end
				3'd1: begin opa = {11'd0, cx_q[CW-2:16]}; opb = {2'd0, INV_GAIN_Q32}; end
				3'd2: begin opa = {1'b0, am}; opb = {2'd0, TWO_PI_Q29}; end
				3'd3: begin opa = {2'd0, prod_q[63:32]}; opb = {2'd0, bpr_q}; end
				default: begin opa = '0; opb = '0; end
			endcase
		end
	end

	assign prod_c = opa * opb;

	// Transform finish: round, shift and translate
	logic signed [51:0] xsum, ysum;
	logic signed [CW-1:0] xt, yt;
	assign xsum = xacc_q + 52'sd32768;
	assign ysum = yacc_q + 52'sd32768;
	assign xt = CW'($signed(xsum[51:16])) + CW'(tx_q);
	assign yt = CW'($signed(ysum[51:16])) + CW'(ty_q);

	// CORDIC step
	logic signed [CW-1:0] xs, ys;
	logic [31:0] atan_v;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign atan_v = atan_fn(it_q);

	// Gain correction sum
	logic [56:0] gsum;
	assign gsum = 57'(prod_q[55:0]) + 57'(t_q);

	// Bin selection
	logic [16:0] nb_e;
	logic signed [36:0] sbase, sv, sabs;
	logic [37:0] rsum;
	logic [21:0] mag;
	logic reject;
	assign nb_e = ({6'd0, num_bins_q} > MAXB) ? MAXB : {6'd0, num_bins_q};
	assign sbase = 37'({nb_e, 15'd0});
	assign sv = ang_q[33] ? sbase - 37'(bq_q) : sbase + 37'(bq_q);
	assign sabs = sv[36] ? -sv : sv;
	assign rsum = 38'(sabs) + 38'd32768;
	assign mag = rsum[37:16];
	assign reject = (sv[36] && (mag != '0)) || (mag >= 22'(nb_e));

	logic upd;
	assign upd = rdr_q > rng_q;

	logic [16:0] rb17;
	assign rb17 = {7'd0, s_tdata[81:72]};

	assign s_tready = (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: if (sweep_q == LAST_BIN) state_d = sweep_emit_q ? ST_EMIT : ST_IDLE;
			ST_IDLE: begin
				if (s_tvalid) begin
					case (action_t'(s_tuser))
						ACT_CLEAR: state_d = ST_SWEEP;
						ACT_PROJECT: state_d = ST_XMUL;
						ACT_READ: state_d = ST_LOOK;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_XMUL: if (cnt_q == 3'd4) state_d = ST_XFIN;
			ST_XFIN: state_d = ST_CINIT;
			ST_CINIT: state_d = ((cx_q == '0) && (cy_q == '0)) ? ST_POST : ST_CORD;
			ST_CORD: if (it_q == LAST_IT) state_d = ST_POST;
			ST_POST: if (cnt_q == 3'd4) state_d = ST_BIN;
			ST_BIN: state_d = reject ? ST_EMIT : ST_LOOK;
			ST_LOOK: state_d = ST_FIN;
			ST_FIN: state_d = ST_EMIT;
			ST_EMIT: if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_SWEEP;
		else state_q <= state_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= 11'd1024;
			bpr_q <= 32'd10680707;
			cos_q <= 18'sd65536;
			sin_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			empty_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_NUM_BINS: num_bins_q <= cfg_data[10:0];
				REG_BINS_PER_RAD: bpr_q <= cfg_data;
				REG_ROT_COS: cos_q <= cfg_data[17:0];
				REG_ROT_SIN: sin_q <= cfg_data[17:0];
				REG_TRANS_X: tx_q <= cfg_data;
				REG_TRANS_Y: ty_q <= cfg_data;
				REG_EMPTY_LABEL: empty_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			it_q <= '0;
			sweep_q <= '0;
			sweep_lbl_q <= '0;
			sweep_emit_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + 3'd1;
			if (state_q == ST_CORD) it_q <= it_q + 5'd1;
			else it_q <= '0;
			if (state_q == ST_SWEEP) sweep_q <= sweep_q + BW'(1);
			else sweep_q <= '0;
			if (state_q == ST_IDLE && s_tvalid && action_t'(s_tuser) == ACT_CLEAR) begin
				sweep_lbl_q <= empty_q;
				sweep_emit_q <= 1'b1;
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (state_q == ST_EMIT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		case (state_q)
			ST_IDLE: begin
				act_q <= s_tuser;
				px_q <= s_tdata[31:0];
				py_q <= s_tdata[63:32];
				lbl_q <= s_tdata[71:64];
				rb_q <= s_tdata[81:72];
				bin_q <= rb17[BW-1:0];
				addr_ok_q <= rb17 < MAXB;
				r_view_q <= 1'b0;
				r_upd_q <= 1'b0;
				r_idx_q <= '0;
				r_rng_q <= '0;
				r_lbl_q <= '0;
			end
			ST_XMUL: begin
				case (cnt_q)
					3'd1: xacc_q <= prod_q[51:0];
					3'd2: xacc_q <= xacc_q - prod_q[51:0];
					3'd3: yacc_q <= prod_q[51:0];
					3'd4: yacc_q <= yacc_q + prod_q[51:0];
					default: ;
				endcase
			end
			ST_XFIN: begin
				cx_q <= xt;
				cy_q <= yt;
			end
			ST_CINIT: begin
				ang_q <= '0;
				if (cx_q[CW-1]) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
					ang_q <= cy_q[CW-1] ? -34'sh080000000 : 34'sh080000000;
				end
			end
			ST_CORD: begin
				if (!cy_q[CW-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					ang_q <= ang_q + 34'(atan_v);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					ang_q <= ang_q - 34'(atan_v);
				end
			end
			ST_POST: begin
				case (cnt_q)
					3'd1: t_q <= prod_q[47:16];
					3'd2: rng_q <= (gsum[56:48] != '0) ? 32'hFFFF_FFFF : gsum[47:16];
					3'd4: bq_q <= prod_q[63:29];
					default: ;
				endcase
			end
			ST_BIN: begin
				bin_q <= mag[BW-1:0];
				addr_ok_q <= 1'b1;
				r_idx_q <= reject ? 10'd0 : mag[9:0];
			end
			ST_FIN: begin
				if (act_q == ACT_PROJECT) begin
					r_view_q <= 1'b1;
					r_upd_q <= upd;
					r_rng_q <= upd ? rng_q : rdr_q;
					r_lbl_q <= upd ? lbl_q : rdl_q;
				end else begin
					r_view_q <= {7'd0, rb_q} < nb_e;
					r_idx_q <= rb_q;
					r_rng_q <= addr_ok_q ? rdr_q : '0;
					r_lbl_q <= addr_ok_q ? rdl_q : '0;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid || m_tready)
					m_tdata <= {4'd0, r_lbl_q, r_rng_q, r_idx_q, r_upd_q, r_view_q};
			end
			default: ;
		endcase
	end

	// Bin memory: one write port, one registered read port
	logic mem_we;
	logic [BW-1:0] mem_wa;
	logic [31:0] mem_wr;
	logic [7:0] mem_wl;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_q;
		mem_wr = CLEAR_RANGE;
		mem_wl = sweep_lbl_q;
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FIN && act_q == ACT_PROJECT && upd) begin
			mem_we = 1'b1;
			mem_wa = bin_q;
			mem_wr = rng_q;
			mem_wl = lbl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			range_mem[mem_wa] <= mem_wr;
			label_mem[mem_wa] <= mem_wl;
		end
		rdr_q <= range_mem[bin_q];
		rdl_q <= label_mem[bin_q];
	end

	// Checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a second item while busy");
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !s_tready)
		else $error("input ready during memory sweep");
	a_upd_in_view: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> m_tdata[0])
		else $error("update flagged outside view");

endmodule
`default_nettype wire
